/* rtl/hdmm_pkg.sv */
`default_nettype none
package hdmm_pkg;

  localparam int unsigned SLOT_COUNT = 256;

  localparam logic [63:0] MUL_X     = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MUL_Y     = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MUL_OWNER = 64'h165667B19E3779F9;
  localparam int unsigned HASH_SHIFT = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        owner_id;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] stored_value;
    logic [7:0]         slot_number;
  } out_item_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_X,
    SEL_Y,
    SEL_OWNER
  } sel_t;

  typedef struct packed {
    logic clr;
    logic load;
    sel_t sel;
    logic acc;
    logic rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/hashed_direct_mapped_memo_core.sv */
`default_nettype none
// Direct-mapped memo table indexed by a multiplicative hash of owner id and
// a signed coordinate pair.
// Input channel in_valid/in_ready/in_item: operation lookup or fill, owner id,
// coordinates and fill value. Result channel out_valid/out_ready/out_item: hit,
// stored value (slot value on hit, echoed value on fill, else 0) and slot number.
// One item is in work at a time; from acceptance it passes through the shared
// 32x32 hash multiplier (one product per coordinate and owner, then the last
// fold), the registered slot read, and the compare and write into the result
// register.
// After reset the table runs a clearing pass over all SLOT_COUNT slots, one slot a
// cycle, with in_ready low; then all slots are empty.
// A finished result waits in the output register while the next item is
// accepted and hashed; if the receiver still stalls when that next result is
// ready, the block holds it in its final step until the register frees up.
module hashed_direct_mapped_memo_core #(
  parameter int unsigned SLOT_COUNT = hdmm_pkg::SLOT_COUNT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hdmm_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hdmm_pkg::out_item_t out_item
);

  hdmm_pkg::cmd_t cmd;
  hdmm_pkg::sts_t sts;

  hdmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdmm_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

/* rtl/hdmm_ctrl.sv */
`default_nettype none
module hdmm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hdmm_pkg::sts_t sts,
  output hdmm_pkg::cmd_t     cmd
);

  localparam logic [1:0] LAST_STEP = 2'd3;

  hdmm_pkg::state_t state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hdmm_pkg::ST_CLEAR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = hdmm_pkg::SEL_X;
    in_ready  = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      hdmm_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = hdmm_pkg::ST_IDLE;
        end
      end
      hdmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = hdmm_pkg::ST_HASH;
        end
      end
      hdmm_pkg::ST_HASH: begin
        unique case (step_r)
          2'd0:    cmd.sel = hdmm_pkg::SEL_X;
          2'd1:    cmd.sel = hdmm_pkg::SEL_Y;
          default: cmd.sel = hdmm_pkg::SEL_OWNER;
        endcase
        cmd.acc = (step_r != 2'd0);
        if (step_r == LAST_STEP) begin
          state_nxt = hdmm_pkg::ST_READ;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      hdmm_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = hdmm_pkg::ST_DONE;
      end
      hdmm_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = hdmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hdmm_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/hdmm_dp.sv */
`default_nettype none
module hdmm_dp #(
  parameter int unsigned SLOT_COUNT = hdmm_pkg::SLOT_COUNT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hdmm_pkg::in_item_t in_item,
  input  wire hdmm_pkg::cmd_t cmd,
  output hdmm_pkg::sts_t     sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hdmm_pkg::out_item_t out_item
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] SLOT_MASK = IDX_W'(SLOT_COUNT - 1);
  localparam logic [IDX_W-1:0] CLR_LAST  = IDX_W'(SLOT_COUNT - 1);

  hdmm_pkg::in_item_t  in_r;
  hdmm_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  hdmm_pkg::slot_t     mem [SLOT_COUNT];
  hdmm_pkg::slot_t     rd_r;
  hdmm_pkg::slot_t     wd;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic [IDX_W-1:0]    acc_r, acc_nxt;
  logic [IDX_W-1:0]    prod_r, cross_r;
  logic [IDX_W-1:0]    idx, wa;
  logic [IDX_W+7:0]    idx_wide;
  logic                we;
  logic                hit_c;

  logic [31:0]         op_lo, op_hi;
  logic [63:0]         k;
  logic [63:0]         prod_full;
  logic [2*IDX_W-1:0]  cross_a, cross_b;

  always_comb begin
    unique case (cmd.sel)
      hdmm_pkg::SEL_X: begin
        op_lo = in_r.coord_x;
        op_hi = {32{in_r.coord_x[31]}};
        k     = hdmm_pkg::MUL_X;
      end
      hdmm_pkg::SEL_Y: begin
        op_lo = in_r.coord_y;
        op_hi = {32{in_r.coord_y[31]}};
        k     = hdmm_pkg::MUL_Y;
      end
      hdmm_pkg::SEL_OWNER: begin
        op_lo = {16'b0, in_r.owner_id};
        op_hi = '0;
        k     = hdmm_pkg::MUL_OWNER;
      end
      default: begin
        op_lo = '0;
        op_hi = '0;
        k     = '0;
      end
    endcase
  end

  // product of the low words gives the hash bits; cross terms only feed their low bits
  assign prod_full = op_lo * k[31:0];
  assign cross_a   = op_hi[IDX_W-1:0] * k[IDX_W-1:0];
  assign cross_b   = op_lo[IDX_W-1:0] * k[hdmm_pkg::HASH_SHIFT +: IDX_W];

  always_ff @(posedge clk) begin
    prod_r  <= prod_full[hdmm_pkg::HASH_SHIFT +: IDX_W];
    cross_r <= cross_a[IDX_W-1:0] + cross_b[IDX_W-1:0];
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load) begin
      acc_nxt = '0;
    end else if (cmd.acc) begin
      acc_nxt = acc_r ^ (prod_r + cross_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  assign idx      = acc_r & SLOT_MASK;
  assign idx_wide = (IDX_W + 8)'(idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt_r == CLR_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  assign we = cmd.clr || (cmd.finish && in_r.operation == hdmm_pkg::OP_FILL);
  assign wa = cmd.clr ? clr_cnt_r : idx;

  always_comb begin
    wd = '0;
    if (!cmd.clr) begin
      wd.owner   = in_r.owner_id;
      wd.coord_x = in_r.coord_x;
      wd.coord_y = in_r.coord_y;
      wd.value   = in_r.fill_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd) begin
      rd_r <= mem[idx];
    end
  end

  assign hit_c = (in_r.operation == hdmm_pkg::OP_LOOKUP) && (in_r.owner_id != 16'd0)
              && (rd_r.owner == in_r.owner_id) && (rd_r.coord_x == in_r.coord_x)
              && (rd_r.coord_y == in_r.coord_y);

  always_comb begin
    out_nxt             = out_r;
    out_nxt.hit         = hit_c;
    out_nxt.slot_number = idx_wide[7:0];
    if (in_r.operation == hdmm_pkg::OP_FILL) begin
      out_nxt.stored_value = in_r.fill_value;
    end else if (hit_c) begin
      out_nxt.stored_value = rd_r.value;
    end else begin
      out_nxt.stored_value = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result written over an item not yet taken");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished item not presented");

  a_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !(cmd.load || cmd.finish || cmd.rd))
    else $error("item activity during clearing pass");

  a_fill_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && in_r.operation == hdmm_pkg::OP_FILL) |=> !out_r.hit)
    else $error("fill reported a hit");

endmodule
`default_nettype wire

/* bench/hashed_direct_mapped_memo_core_test.sv */
`timescale 1ns / 100ps

module hashed_direct_mapped_memo_core_test;

  localparam int RANDOM_PER_PHASE = 310;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int POOL_DEPTH = 32;
  localparam logic [31:0] COORD_MIN = 32'h8000_0000;
  localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;

  typedef struct {
    hdmm_pkg::in_item_t item;
    bit                 known;
    logic               hit;
    logic signed [31:0] value;
  } probe_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  hdmm_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  hdmm_pkg::out_item_t out_item;

  logic [15:0] memo_owner [hdmm_pkg::SLOT_COUNT];
  logic [31:0] memo_x [hdmm_pkg::SLOT_COUNT];
  logic [31:0] memo_y [hdmm_pkg::SLOT_COUNT];
  logic [31:0] memo_value [hdmm_pkg::SLOT_COUNT];

  hdmm_pkg::out_item_t pending[$];
  hdmm_pkg::in_item_t  key_pool[$];
  probe_row_t          probes[$];
  hdmm_pkg::out_item_t oldest;

  int  snd_idle_pct;
  int  rcv_idle_pct;
  bit  hold_req;
  int  mismatches;
  int  n_items;
  int  n_lookups;
  int  n_hits;
  int  n_fills;
  int  n_results;
  int  stall_cycles;

  hashed_direct_mapped_memo_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] slot_of(logic [15:0] owner, logic [31:0] x, logic [31:0] y);
    logic [63:0] h;
    logic [63:0] xe;
    logic [63:0] ye;
    xe = {{32{x[31]}}, x};
    ye = {{32{y[31]}}, y};
    h = xe * hdmm_pkg::MUL_X;
    h = h ^ (ye * hdmm_pkg::MUL_Y);
    h = h ^ ({48'd0, owner} * hdmm_pkg::MUL_OWNER);
    return 32'((h >> hdmm_pkg::HASH_SHIFT) & 64'(hdmm_pkg::SLOT_COUNT - 1));
  endfunction

  function automatic hdmm_pkg::out_item_t predict_memo(hdmm_pkg::in_item_t it);
    hdmm_pkg::out_item_t r;
    logic [31:0]         s;
    s = slot_of(it.owner_id, it.coord_x, it.coord_y);
    r = '0;
    r.slot_number = s[7:0];
    if (it.operation == hdmm_pkg::OP_FILL) begin
      memo_owner[s] = it.owner_id;
      memo_x[s] = it.coord_x;
      memo_y[s] = it.coord_y;
      memo_value[s] = it.fill_value;
      r.stored_value = it.fill_value;
      n_fills++;
    end else begin
      n_lookups++;
      if (it.owner_id != 16'd0 && memo_owner[s] == it.owner_id &&
          memo_x[s] == it.coord_x && memo_y[s] == it.coord_y) begin
        r.hit = 1'b1;
        r.stored_value = memo_value[s];
        n_hits++;
      end
    end
    return r;
  endfunction

  function automatic probe_row_t probe(logic op, logic [15:0] owner, logic [31:0] x,
                                       logic [31:0] y, logic [31:0] v, bit known,
                                       logic h, logic [31:0] kv);
    probe_row_t p;
    p.item.operation = op;
    p.item.owner_id = owner;
    p.item.coord_x = x;
    p.item.coord_y = y;
    p.item.fill_value = v;
    p.known = known;
    p.hit = h;
    p.value = kv;
    return p;
  endfunction

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 16)) - 32'd8;
      1: return COORD_MIN;
      2: return COORD_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] random_owner();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic hdmm_pkg::in_item_t random_item();
    hdmm_pkg::in_item_t it;
    int                 r;
    int                 k;
    r = $urandom_range(0, 99);
    it.fill_value = $urandom;
    if (r < 20 || key_pool.size() == 0) begin
      it.operation = $urandom_range(0, 1) ? hdmm_pkg::OP_FILL : hdmm_pkg::OP_LOOKUP;
      it.owner_id = random_owner();
      it.coord_x = random_coord();
      it.coord_y = random_coord();
    end else if (r < 50 && $urandom_range(0, 1) == 1) begin
      it.operation = hdmm_pkg::OP_FILL;
      it.owner_id = random_owner();
      it.coord_x = random_coord();
      it.coord_y = random_coord();
      if (key_pool.size() < POOL_DEPTH) key_pool.push_back(it);
      else key_pool[$urandom_range(0, POOL_DEPTH - 1)] = it;
    end else begin
      k = $urandom_range(0, key_pool.size() - 1);
      it.owner_id = key_pool[k].owner_id;
      it.coord_x = key_pool[k].coord_x;
      it.coord_y = key_pool[k].coord_y;
      it.operation = (r < 50) ? hdmm_pkg::OP_FILL : hdmm_pkg::OP_LOOKUP;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  task automatic offer_item(probe_row_t p);
    hdmm_pkg::out_item_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= p.item;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    want = predict_memo(p.item);
    if (p.known) begin
      want.hit = p.hit;
      want.stored_value = p.value;
    end
    pending.push_back(want);
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, slot", -1, out_item.slot_number);
      end else begin
        oldest = pending.pop_front();
        if (out_item.hit !== oldest.hit)
          report_mismatch("hit", oldest.hit, out_item.hit);
        if (out_item.stored_value !== oldest.stored_value)
          report_mismatch("stored_value", oldest.stored_value, out_item.stored_value);
        if (out_item.slot_number !== oldest.slot_number)
          report_mismatch("slot_number", oldest.slot_number, out_item.slot_number);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          other;
    logic [31:0] base_slot;
    probe_row_t  p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    hold_req = 1'b0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int s = 0; s < hdmm_pkg::SLOT_COUNT; s++) memo_owner[s] = 16'd0;

    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'd1, 32'd0, 32'd0, 32'd7, 1, 1'b0,
                           32'd0));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'hFFFF, COORD_MIN, COORD_MAX, 32'd0, 1,
                           1'b0, 32'd0));
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'd1, 32'd0, 32'd0, COORD_MAX, 1, 1'b0,
                           COORD_MAX));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'd1, 32'd0, 32'd0, 32'd0, 1, 1'b1,
                           COORD_MAX));
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'hFFFF, COORD_MIN, COORD_MAX, COORD_MIN, 1,
                           1'b0, COORD_MIN));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'hFFFF, COORD_MIN, COORD_MAX, 32'd0, 1,
                           1'b1, COORD_MIN));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'hFFFE, COORD_MIN, COORD_MAX, 32'd0, 0,
                           1'b0, 32'd0));
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'd0, 32'd5, -32'sd5, 32'd123, 1, 1'b0,
                           32'd123));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'd0, 32'd5, -32'sd5, 32'd0, 1, 1'b0,
                           32'd0));
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 1, 1'b0, 32'hFFFF_FFFF));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'h8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'd0, 1, 1'b1, 32'hFFFF_FFFF));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'h8000, 32'hFFFF_FFFF, 32'd0, 32'd0, 0,
                           1'b0, 32'd0));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'h8000, COORD_MAX, COORD_MIN, 32'd0, 0,
                           1'b0, 32'd0));
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'd1, 32'd0, 32'd0, 32'd0, 1, 1'b0, 32'd0));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'd1, 32'd0, 32'd0, 32'd0, 1, 1'b1,
                           32'd0));

    // find a second owner hashing onto the slot of owner 1 at the origin
    base_slot = slot_of(16'd1, 32'd0, 32'd0);
    other = 2;
    while (slot_of(16'(other), 32'd0, 32'd0) != base_slot) other++;
    probes.push_back(probe(hdmm_pkg::OP_FILL, 16'(other), 32'd0, 32'd0, 32'h55, 1, 1'b0,
                           32'h55));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'd1, 32'd0, 32'd0, 32'd0, 1, 1'b0,
                           32'd0));
    probes.push_back(probe(hdmm_pkg::OP_LOOKUP, 16'(other), 32'd0, 32'd0, 32'd0, 1, 1'b1,
                           32'h55));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 24;
          rcv_idle_pct = 81;
        end
        1: begin
          snd_idle_pct = 81;
          rcv_idle_pct = 24;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (probes[i]) offer_item(probes[i]);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 2 && i == 50) hold_req = 1'b1;
        p.item = random_item();
        p.known = 0;
        p.hit = 1'b0;
        p.value = '0;
        offer_item(p);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d items: %0d lookups with %0d hits, %0d fills, %0d results checked",
             n_items, n_lookups, n_hits, n_fills, n_results);
    $display("three pacing phases, one long result stall, %0d mismatches", mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hdmm_pkg.sv
rtl/hdmm_ctrl.sv
rtl/hdmm_dp.sv
rtl/hashed_direct_mapped_memo_core.sv
bench/hashed_direct_mapped_memo_core_test.sv
